>>> sv/plob_pkg.sv
// ----------------------------------------------------------------------------
// plob_pkg: shared types and constants of the price level order book
// Status codes, sizes and the controller to datapath command struct.
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int MAX_ORDERS_DEF   = 4096;
    localparam int PRICE_LEVELS_DEF = 1024;
    localparam int CNT_W            = 13;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [31:0] EMPTY_ASK = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_ID    = 2'd1,
        ST_ABSENT    = 2'd2,
        ST_BAD_PRICE = 2'd3
    } t_status;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_CANCEL = 1'b1
    } t_opcode;

    // controller -> datapath
    typedef struct packed {
        logic clr;      // clearing pass, one entry per cycle
        logic load;     // capture input word, read order table
        logic rd;       // read level counts
        logic upd;      // apply add/cancel
        logic scan_init;
        logic scan_rd;  // read counts at scan level
        logic scan_step;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic need_scan;
        logic scan_done;
    } t_stat;

endpackage

>>> sv/plob_ctrl.sv
// ----------------------------------------------------------------------------
// plob_ctrl: request sequencer
// Clear after reset; then load, read, update, optional rescan, hold result.
// ----------------------------------------------------------------------------
module plob_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output plob_pkg::t_cmd  o_cmd,
    input  plob_pkg::t_stat i_stat
);
    import plob_pkg::*;

    typedef enum logic [7:0] {
        S_CLR  = 8'b00000001,
        S_IDLE = 8'b00000010,
        S_RD   = 8'b00000100,
        S_UPD  = 8'b00001000,
        S_SINI = 8'b00010000,
        S_SRD  = 8'b00100000,
        S_SCHK = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_stat.need_scan ? S_SINI : S_OUT;
            end
            S_SINI: begin
                o_cmd.scan_init = 1'b1;
                n_state         = S_SRD;
            end
            S_SRD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCHK;
            end
            S_SCHK: begin
                o_cmd.scan_step = 1'b1;
                n_state         = i_stat.scan_done ? S_OUT : S_SRD;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLR;
        else          r_state <= n_state;
    end
endmodule

>>> sv/plob_dp.sv
// ----------------------------------------------------------------------------
// plob_dp: order book datapath
// Order table, per-level counts, best registers and the level scanner.
// ----------------------------------------------------------------------------
module plob_dp #(
    parameter int MAX_ORDERS   = plob_pkg::MAX_ORDERS_DEF,
    parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_opcode,
    input  logic [15:0]     i_order_ident,
    input  logic            i_is_sell,
    input  logic [31:0]     i_order_price,
    input  plob_pkg::t_cmd  i_cmd,
    output plob_pkg::t_stat o_stat,
    output logic [1:0]      o_status,
    output logic [31:0]     o_best_bid,
    output logic [31:0]     o_best_ask
);
    import plob_pkg::*;

    localparam int OW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int LW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int CLR_N = (MAX_ORDERS > PRICE_LEVELS) ? MAX_ORDERS : PRICE_LEVELS;
    localparam int CLW = $clog2(CLR_N);
    localparam logic [32:0] NLEV = 33'(PRICE_LEVELS);
    localparam logic [LW-1:0] TOP = LW'(PRICE_LEVELS - 1);
    localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_N - 1);
    localparam logic [CLW-1:0] ORD_LAST = CLW'(MAX_ORDERS - 1);
    localparam logic [CLW-1:0] LEV_LAST = CLW'(PRICE_LEVELS - 1);

    logic [31:0] r_base;

    // captured request
    logic        r_op, r_sell;
    logic [15:0] r_id;
    logic [31:0] r_price;

    // order table and level count stores
    logic             mem_side  [MAX_ORDERS];
    logic [LW-1:0]    mem_level [MAX_ORDERS];
    logic             mem_valid [MAX_ORDERS];
    logic [CNT_W-1:0] bid_cnt   [PRICE_LEVELS];
    logic [CNT_W-1:0] ask_cnt   [PRICE_LEVELS];

    logic             r_t_valid, r_t_side;
    logic [LW-1:0]    r_t_level;
    logic [CNT_W-1:0] r_bid_q, r_ask_q;
    logic [CLW-1:0]   r_clr;

    logic [31:0]   r_bid, r_ask;
    logic [1:0]    r_status;
    logic          r_scan_ask, r_scan_abort;
    logic [LW-1:0] r_scan;

    logic             id_bad, price_bad, use_ask, do_add, do_cancel;
    logic             need_scan, scan_hit, scan_end;
    logic [32:0]      add_off, bid_off, ask_off;
    logic [OW-1:0]    id_ix, in_ix;
    logic [LW-1:0]    lvl_ix, cnt_addr;
    logic [CNT_W-1:0] cnt_q, cnt_new;
    logic [31:0]      can_price;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)        r_base <= '0;
        else if (i_cfg_valid) r_base <= i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode; r_id <= i_order_ident;
            r_sell <= i_is_sell; r_price <= i_order_price;
        end
    end

    assign id_bad    = ({16'd0, r_id} >= 32'(MAX_ORDERS));
    assign add_off   = {1'b0, r_price} - {1'b0, r_base};
    assign price_bad = add_off[32] || (add_off >= NLEV);

    assign id_ix  = r_id[OW-1:0];
    assign in_ix  = i_order_ident[OW-1:0];
    assign lvl_ix = (r_op == OP_ADD) ? add_off[LW-1:0] : r_t_level;

    assign use_ask   = (r_op == OP_ADD) ? r_sell : r_t_side;
    assign do_add    = !id_bad && (r_op == OP_ADD) && !price_bad;
    assign do_cancel = !id_bad && (r_op == OP_CANCEL) && r_t_valid;

    // clearing pass after reset: one table entry and one level per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                          r_clr <= '0;
        else if (i_cmd.clr && r_clr != CLR_LAST) r_clr <= r_clr + 1'b1;
    end
    assign o_stat.clr_done = (r_clr == CLR_LAST);

    // order table: read while the word is accepted
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (r_clr <= ORD_LAST) mem_valid[r_clr[OW-1:0]] <= 1'b0;
        end else if (i_cmd.upd && (do_add || do_cancel)) begin
            mem_valid[id_ix] <= do_add;
        end
        if (i_cmd.upd && do_add) begin
            mem_side[id_ix]  <= r_sell;
            mem_level[id_ix] <= add_off[LW-1:0];
        end
        if (i_cmd.load) begin
            r_t_valid <= mem_valid[in_ix];
            r_t_side  <= mem_side[in_ix];
            r_t_level <= mem_level[in_ix];
        end
    end

    // level counts: one read address per cycle, request level or scan level
    assign cnt_addr = i_cmd.scan_rd ? r_scan : lvl_ix;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            if (r_clr <= LEV_LAST) begin
                bid_cnt[r_clr[LW-1:0]] <= '0;
                ask_cnt[r_clr[LW-1:0]] <= '0;
            end
        end else if (i_cmd.upd && (do_add || do_cancel)) begin
            if (use_ask) ask_cnt[lvl_ix] <= cnt_new;
            else         bid_cnt[lvl_ix] <= cnt_new;
        end
        if (i_cmd.rd || i_cmd.scan_rd) begin
            r_bid_q <= bid_cnt[cnt_addr];
            r_ask_q <= ask_cnt[cnt_addr];
        end
    end

    assign cnt_q = use_ask ? r_ask_q : r_bid_q;

    always_comb begin
        cnt_new = cnt_q;
        if (do_add && cnt_q != COUNT_MAX) cnt_new = cnt_q + 1'b1;
        if (do_cancel && cnt_q != '0)     cnt_new = cnt_q - 1'b1;
    end

    assign can_price = r_base + 32'(r_t_level);

    // bests and scanner
    assign scan_hit = r_scan_ask ? (r_ask_q != '0) : (r_bid_q != '0);
    assign scan_end = r_scan_ask ? (r_scan == TOP) : (r_scan == '0);

    assign need_scan = do_cancel && (use_ask ? (can_price == r_ask)
                                             : (can_price == r_bid));
    assign o_stat.need_scan = need_scan;
    assign o_stat.scan_done = r_scan_abort || scan_hit || scan_end;

    assign bid_off = {1'b0, r_bid} - {1'b0, r_base};
    assign ask_off = {1'b0, r_ask} - {1'b0, r_base};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bid <= '0; r_ask <= EMPTY_ASK;
        end else begin
            if (i_cmd.upd) begin
                r_scan_ask <= use_ask;
                if (do_add && !r_sell && r_price > r_bid) r_bid <= r_price;
                if (do_add &&  r_sell && r_price < r_ask) r_ask <= r_price;
            end
            if (i_cmd.scan_init) begin
                if (r_scan_ask) begin
                    if (ask_off[32])            r_scan <= '0;
                    else if (ask_off >= NLEV) begin
                        r_scan <= TOP; r_ask <= EMPTY_ASK;
                    end else                    r_scan <= ask_off[LW-1:0];
                    r_scan_abort <= !ask_off[32] && (ask_off >= NLEV);
                end else begin
                    if (bid_off[32]) begin
                        r_scan <= '0; r_bid <= '0;
                    end else if (bid_off >= NLEV) r_scan <= TOP;
                    else                          r_scan <= bid_off[LW-1:0];
                    r_scan_abort <= bid_off[32];
                end
            end
            if (i_cmd.scan_step && !r_scan_abort) begin
                if (scan_hit) begin
                    if (r_scan_ask) r_ask <= r_base + 32'(r_scan);
                    else            r_bid <= r_base + 32'(r_scan);
                end else if (scan_end) begin
                    if (r_scan_ask) r_ask <= EMPTY_ASK; else r_bid <= '0;
                end else begin
                    r_scan <= r_scan_ask ? r_scan + 1'b1 : r_scan - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            if (id_bad)                   r_status <= ST_BAD_ID;
            else if (r_op == OP_ADD)      r_status <= price_bad ? ST_BAD_PRICE : ST_OK;
            else                          r_status <= r_t_valid ? ST_OK : ST_ABSENT;
        end
    end

    assign o_status   = r_status;
    assign o_best_bid = r_bid;
    assign o_best_ask = r_ask;
endmodule

>>> sv/price_level_order_book.sv
// ----------------------------------------------------------------------------
// price_level_order_book: best bid / best ask tracker
// Add and cancel requests against an order table and per-level counts.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                tuser
//  s_axis    in   order_ident, is_sell, order_price    opcode
//  m_axis    out  best_bid, best_ask                   status
//  cfg       in   base_price (32 bits)                 -
//
//  After reset a clearing pass over max(MAX_ORDERS, PRICE_LEVELS) entries
//  (4096 by default) zeroes the valid bits and level counts; s_axis_tready
//  stays low until it ends. Reset is synchronous, active low.
//  A word passes through accept with table read, count read, update, result.
//  Cancelling the best level adds a rescan: a start step, then a count read
//  and a test per level visited, at most PRICE_LEVELS levels.
//  One word in flight; a stalled result holds s_axis_tready low until taken.
// ----------------------------------------------------------------------------
module price_level_order_book #(
    parameter int MAX_ORDERS   = plob_pkg::MAX_ORDERS_DEF,
    parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // order_ident[15:0], is_sell[16], order_price[48:17]
    input  logic [55:0] s_axis_tdata,
    // opcode[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // best_bid[31:0], best_ask[63:32]
    output logic [63:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import plob_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [1:0]  status;
    logic [31:0] bb, ba;

    assign o_cfg_ready = 1'b1;

    plob_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd), .i_stat(stat)
    );

    plob_dp #(.MAX_ORDERS(MAX_ORDERS), .PRICE_LEVELS(PRICE_LEVELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_data(i_cfg_data),
        .i_opcode(s_axis_tuser), .i_order_ident(s_axis_tdata[15:0]),
        .i_is_sell(s_axis_tdata[16]), .i_order_price(s_axis_tdata[48:17]),
        .i_cmd(cmd), .o_stat(stat),
        .o_status(status), .o_best_bid(bb), .o_best_ask(ba)
    );

    assign m_axis_tdata = {ba, bb};
    assign m_axis_tuser = status;
endmodule

>>> verif/tb_price_level_order_book.sv
// ----------------------------------------------------------------------------
// tb_price_level_order_book: self-checking bench for the order book
// Directed table then random add/cancel traffic under several idling phases
// and base price settings; every result word is checked against a predictor.
// ----------------------------------------------------------------------------
module tb_price_level_order_book;
    timeunit 1ns;
    timeprecision 1ps;
    import plob_pkg::*;

    localparam int NORD = MAX_ORDERS_DEF;
    localparam int NLVL = PRICE_LEVELS_DEF;
    localparam longint CYCLE_LIMIT = 20000000;
    localparam int HOLD_LEN = 300;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bid;
        logic [31:0] ask;
    } t_book_result;

    // directed row: request plus optional typed-in result
    typedef struct {
        t_opcode     op;
        logic [15:0] ident;
        logic        sell;
        logic [31:0] price;
        bit          fixed;
        t_status     st;
        logic [31:0] bid;
        logic [31:0] ask;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    price_level_order_book u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor copy of the book
    logic [31:0]      bk_base;
    bit               bk_valid [NORD];
    logic             bk_side  [NORD];
    logic [9:0]       bk_level [NORD];
    logic [CNT_W-1:0] bk_bids  [NLVL];
    logic [CNT_W-1:0] bk_asks  [NLVL];
    logic [31:0]      bk_best_bid;
    logic [31:0]      bk_best_ask;

    t_book_result pending_results[$];
    int           mismatches = 0;
    longint       cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_req = 1'b0;
    int           hold_count = 0;
    int           live_ids[$];   // ids believed resting, to aim cancels at

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want,
                 cycle_count);
        mismatches++;
    endtask

    function automatic void book_reset();
        bk_base = '0;
        foreach (bk_valid[i]) begin
            bk_valid[i] = 1'b0;
            bk_side[i] = 1'b0;
            bk_level[i] = '0;
        end
        foreach (bk_bids[i]) begin
            bk_bids[i] = '0;
            bk_asks[i] = '0;
        end
        bk_best_bid = '0;
        bk_best_ask = EMPTY_ASK;
    endfunction

    function automatic void rescan_bids();
        logic [31:0] start;
        if (bk_best_bid < bk_base) begin
            bk_best_bid = '0;
            return;
        end
        start = bk_best_bid - bk_base;
        if (start >= NLVL) start = 32'(NLVL - 1);
        for (int i = int'(start); i >= 0; i--) begin
            if (bk_bids[i] != 0) begin
                bk_best_bid = bk_base + 32'(i);
                return;
            end
        end
        bk_best_bid = '0;
    endfunction

    function automatic void rescan_asks();
        logic [31:0] start;
        start = (bk_best_ask < bk_base) ? 32'd0 : bk_best_ask - bk_base;
        if (start < NLVL) begin
            for (int i = int'(start); i < NLVL; i++) begin
                if (bk_asks[i] != 0) begin
                    bk_best_ask = bk_base + 32'(i);
                    return;
                end
            end
        end
        bk_best_ask = EMPTY_ASK;
    endfunction

    function automatic t_book_result book_apply(input t_opcode op,
            input logic [15:0] ident, input logic sell, input logic [31:0] price);
        t_book_result r;
        logic [31:0] lvl;
        logic [31:0] lp;
        t_status st;
        st = ST_OK;
        if (ident >= NORD) begin
            st = ST_BAD_ID;
        end else if (op == OP_ADD) begin
            lvl = price - bk_base;
            if (price < bk_base || lvl >= NLVL) begin
                st = ST_BAD_PRICE;
            end else begin
                bk_valid[ident] = 1'b1;
                bk_side[ident] = sell;
                bk_level[ident] = lvl[9:0];
                if (!sell) begin
                    if (bk_bids[lvl] != COUNT_MAX) bk_bids[lvl]++;
                    if (price > bk_best_bid) bk_best_bid = price;
                end else begin
                    if (bk_asks[lvl] != COUNT_MAX) bk_asks[lvl]++;
                    if (price < bk_best_ask) bk_best_ask = price;
                end
            end
        end else if (!bk_valid[ident]) begin
            st = ST_ABSENT;
        end else begin
            lp = bk_base + 32'(bk_level[ident]);
            bk_valid[ident] = 1'b0;
            if (!bk_side[ident]) begin
                if (bk_bids[bk_level[ident]] != 0) bk_bids[bk_level[ident]]--;
                if (lp == bk_best_bid) rescan_bids();
            end else begin
                if (bk_asks[bk_level[ident]] != 0) bk_asks[bk_level[ident]]--;
                if (lp == bk_best_ask) rescan_asks();
            end
        end
        r.status = st;
        r.bid = bk_best_bid;
        r.ask = bk_best_ask;
        return r;
    endfunction

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_req && hold_count < HOLD_LEN) begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_book_result got;
        t_book_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tuser;
            got.bid = m_axis_tdata[31:0];
            got.ask = m_axis_tdata[63:32];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", got.bid, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", 32'(got.status), 32'(want.status));
                if (got.bid != want.bid) report_mismatch("best_bid", got.bid, want.bid);
                if (got.ask != want.ask) report_mismatch("best_ask", got.ask, want.ask);
            end
        end
    end

    task automatic send_request(input t_opcode op, input logic [15:0] ident,
                                input logic sell, input logic [31:0] price,
                                input bit fixed, input t_book_result typed);
        t_book_result want;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, price, sell, ident};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        want = book_apply(op, ident, sell, price);
        if (fixed && want != typed)
            report_mismatch("table row vs predictor", 32'(typed.status),
                            32'(want.status));
        pending_results.push_back(want);
        if (op == OP_ADD && want.status == ST_OK) live_ids.push_back(ident);
    endtask

    // let the block drain, including a possible full rescan
    task automatic drain();
        longint t0;
        s_axis_tvalid <= 1'b0;
        t0 = cycle_count;
        while (pending_results.size() != 0 && cycle_count - t0 < 400000)
            @(posedge i_clk);
        repeat (NLVL + 20) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        bk_base = value;
    endtask

    task automatic random_phase(input int count, input logic [31:0] base);
        t_opcode op;
        logic [15:0] ident;
        logic [31:0] price;
        int k;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(99) < 45) ? OP_CANCEL : OP_ADD;
            // mostly well formed: ids in range, prices near the array
            if ($urandom_range(99) < 5) ident = 16'($urandom);
            else ident = 16'($urandom_range(NORD - 1) % 64);
            if ($urandom_range(99) < 5) price = $urandom;
            else price = base + 32'($urandom_range(NLVL + 3)) - 32'd2;
            if (op == OP_CANCEL && live_ids.size() != 0 && $urandom_range(3) != 0) begin
                k = $urandom_range(live_ids.size() - 1);
                ident = 16'(live_ids[k]);
                live_ids.delete(k);
            end
            send_request(op, ident, 1'($urandom_range(1)), price, 1'b0, '0);
        end
    endtask

    initial begin
        t_row rows[$];
        t_book_result typed;
        logic [31:0] bases[4];
        book_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, base 0 after reset
        rows = '{
            '{OP_ADD,    16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1, ST_BAD_ID, 0, EMPTY_ASK},
            '{OP_CANCEL, 16'd0,    1'b0, 32'd0,         1, ST_ABSENT, 0, EMPTY_ASK},
            '{OP_ADD,    16'd1,    1'b0, 32'd1024,      1, ST_BAD_PRICE, 0, EMPTY_ASK},
            '{OP_ADD,    16'd0,    1'b0, 32'd0,         1, ST_OK, 0, EMPTY_ASK},
            '{OP_ADD,    16'd1,    1'b0, 32'd1023,      1, ST_OK, 1023, EMPTY_ASK},
            '{OP_ADD,    16'd2,    1'b1, 32'd1023,      1, ST_OK, 1023, 1023},
            '{OP_ADD,    16'd3,    1'b1, 32'd0,         1, ST_OK, 1023, 0},
            '{OP_ADD,    16'd4095, 1'b0, 32'd500,       1, ST_OK, 1023, 0},
            '{OP_ADD,    16'd4096, 1'b0, 32'd5,         1, ST_BAD_ID, 1023, 0},
            '{OP_CANCEL, 16'd1,    1'b1, 32'hFFFF_FFFF, 0, ST_OK, 0, 0},
            '{OP_CANCEL, 16'd3,    1'b0, 32'd0,         0, ST_OK, 0, 0},
            '{OP_CANCEL, 16'd3,    1'b0, 32'd0,         0, ST_OK, 0, 0},
            '{OP_ADD,    16'd5,    1'b0, 32'd700,       0, ST_OK, 0, 0},
            '{OP_ADD,    16'd5,    1'b0, 32'd100,       0, ST_OK, 0, 0},  // re-add
            '{OP_CANCEL, 16'd5,    1'b0, 32'd0,         0, ST_OK, 0, 0},
            '{OP_CANCEL, 16'd4095, 1'b0, 32'd0,         0, ST_OK, 0, 0},
            '{OP_CANCEL, 16'd2,    1'b0, 32'd0,         0, ST_OK, 0, 0},
            '{OP_CANCEL, 16'd0,    1'b0, 32'd0,         0, ST_OK, 0, 0}
        };
        foreach (rows[i]) begin
            typed.status = rows[i].st;
            typed.bid = rows[i].bid;
            typed.ask = rows[i].ask;
            send_request(rows[i].op, rows[i].ident, rows[i].sell, rows[i].price,
                         rows[i].fixed, typed);
        end
        drain();

        // base moved under resting orders, then those orders are cancelled
        write_base(32'd2000);
        send_request(OP_ADD, 16'd7, 1'b0, 32'd2010, 0, '0);
        send_request(OP_ADD, 16'd8, 1'b1, 32'd2011, 0, '0);
        drain();
        write_base(32'd1500);
        send_request(OP_CANCEL, 16'd7, 1'b0, 32'd0, 0, '0);
        send_request(OP_CANCEL, 16'd8, 1'b0, 32'd0, 0, '0);
        drain();

        bases = '{32'd0, 32'hFFFF_FC00, 32'hFFFF_FFFF, 32'h8000_1234};
        for (int ph = 0; ph < 4; ph++) begin
            write_base(bases[ph]);
            live_ids.delete();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (ph == 0) hold_req = 1'b1;
            random_phase(250, bases[ph]);
            hold_req = 1'b0;
            drain();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
